/* rtl/modbus_data_model_register_map_macros.svh */
// ----------------------------------------------------------------------------
// Modbus register map assertion macros
// Shared assertion shorthands for the register map checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_DATA_MODEL_REGISTER_MAP_MACROS_SVH
`define MODBUS_DATA_MODEL_REGISTER_MAP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MDMRM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MDMRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mdmrm_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus register map package
// Command codes, status codes, control types and field widths.
// ----------------------------------------------------------------------------
package mdmrm_pkg;

  typedef enum logic [3:0] {
    CMD_RD_COIL   = 4'd0,
    CMD_RD_DISC   = 4'd1,
    CMD_WR_COIL   = 4'd2,
    CMD_WR_COILS  = 4'd3,
    CMD_RD_HOLD   = 4'd4,
    CMD_RD_INREG  = 4'd5,
    CMD_WR_HOLD   = 4'd6,
    CMD_SET_TAG   = 4'd7,
    CMD_SET_VALUE = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    TBL_COIL  = 2'd0,
    TBL_DISC  = 2'd1,
    TBL_HOLD  = 2'd2,
    TBL_INREG = 2'd3
  } tbl_e;

  typedef enum logic [2:0] {
    REG_SWITCH_ADDR = 3'd0,
    REG_SWITCH_IDX  = 3'd1,
    REG_COIL_USE    = 3'd2,
    REG_DISC_USE    = 3'd3,
    REG_HOLD_USE    = 3'd4,
    REG_INREG_USE   = 3'd5
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } st_e;

  localparam logic [1:0]  STATUS_OK    = 2'd0;
  localparam logic [1:0]  STATUS_MISS  = 2'd1;
  localparam logic [1:0]  STATUS_TRUNC = 2'd2;
  localparam logic [15:0] SWITCH_ADDR_RESET = 16'd10000;
  localparam int unsigned DATA_BITS = 16;
  localparam int unsigned IDXW = 8;
  localparam int unsigned CNTW = 7;

  typedef struct packed {
    logic             look_en;
    tbl_e             look_tbl;
    logic [15:0]      look_addr;
    logic [5:0]       look_use;
    logic             exec_en;
    logic [3:0]       cmd;
    logic             wr_ok;
    tbl_e             tsel;
    logic [4:0]       ent;
    logic [15:0]      data;
    logic [15:0]      tag;
    logic [IDXW-1:0]  first_idx;
    logic [CNTW-1:0]  cnt;
    logic [5:0]       coil_use;
  } cell_ctrl_t;

endpackage

/* rtl/mdmrm_cell.sv */
// ----------------------------------------------------------------------------
// Modbus register map cell
// One entry of all four tables: tags, values, tag compare and write logic.
// ----------------------------------------------------------------------------
module mdmrm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mdmrm_pkg::cell_ctrl_t ctrl_i,
  input  logic                 first_i,
  output logic                 hit_o,
  output logic                 coil_o,
  output logic                 disc_o,
  output logic [15:0]          hold_o,
  output logic [15:0]          inreg_o
);
  import mdmrm_pkg::*;

  logic [15:0] coil_tag_q, disc_tag_q, hold_tag_q, inreg_tag_q;
  logic [15:0] sel_tag;
  logic        hit_q, hit_d;
  logic        coil_q, coil_d, disc_q, disc_d;
  logic [15:0] hold_q, hold_d, inreg_q, inreg_d;
  logic        ent_me, tag_we, burst_we, burst_bit;
  int          off;

  always_comb begin
    case (ctrl_i.look_tbl)
      TBL_COIL: sel_tag = coil_tag_q;
      TBL_DISC: sel_tag = disc_tag_q;
      TBL_HOLD: sel_tag = hold_tag_q;
      default:  sel_tag = inreg_tag_q;
    endcase
    hit_d = (int'(ctrl_i.look_use) > IDX) && (sel_tag == ctrl_i.look_addr);
  end

  always_comb begin
    ent_me    = (int'(ctrl_i.ent) == IDX);
    off       = IDX - int'(ctrl_i.first_idx);
    burst_we  = (off >= 0) && (off < int'(ctrl_i.cnt)) && (int'(ctrl_i.coil_use) > IDX);
    burst_bit = (off >= 0) && (off < DATA_BITS) && ctrl_i.data[4'(off)];
    tag_we    = ctrl_i.exec_en && (ctrl_i.cmd == CMD_SET_TAG) && ent_me;
    coil_d    = coil_q;
    disc_d    = disc_q;
    hold_d    = hold_q;
    inreg_d   = inreg_q;
    if (ctrl_i.exec_en) begin
      case (ctrl_i.cmd)
        CMD_WR_COIL: begin
          if (ctrl_i.wr_ok && first_i) coil_d = (ctrl_i.data != '0);
        end
        CMD_WR_COILS: begin
          if (ctrl_i.wr_ok && burst_we) coil_d = burst_bit;
        end
        CMD_WR_HOLD: begin
          if (ctrl_i.wr_ok && first_i) hold_d = ctrl_i.data;
        end
        CMD_SET_VALUE: begin
          if (ent_me) begin
            case (ctrl_i.tsel)
              TBL_COIL: coil_d  = (ctrl_i.data != '0);
              TBL_DISC: disc_d  = (ctrl_i.data != '0);
              TBL_HOLD: hold_d  = ctrl_i.data;
              default:  inreg_d = ctrl_i.data;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.look_en) hit_q <= hit_d;
    if (tag_we) begin
      case (ctrl_i.tsel)
        TBL_COIL: coil_tag_q  <= ctrl_i.tag;
        TBL_DISC: disc_tag_q  <= ctrl_i.tag;
        TBL_HOLD: hold_tag_q  <= ctrl_i.tag;
        default:  inreg_tag_q <= ctrl_i.tag;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coil_q  <= 1'b0;
      disc_q  <= 1'b0;
      hold_q  <= '0;
      inreg_q <= '0;
    end else begin
      coil_q  <= coil_d;
      disc_q  <= disc_d;
      hold_q  <= hold_d;
      inreg_q <= inreg_d;
    end
  end

  assign hit_o   = hit_q;
  assign coil_o  = coil_q;
  assign disc_o  = disc_q;
  assign hold_o  = hold_q;
  assign inreg_o = inreg_q;

endmodule

/* rtl/modbus_data_model_register_map.sv */
// An accepted item is registered with its tag compare result, and in the execute state its
// result goes to the output register; a result still waiting on the output holds the
// execute state until it is taken. A new item is accepted only in the idle state, so the
// block finishes the tag compare and the execute of one item before it takes the next.
// Reset clears the configuration to its defaults and all coil, discrete and register
// values to zero; tags hold no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// Modbus register map
// Row of table cells with first-match lookup, gated writes and burst coil writes.
// ----------------------------------------------------------------------------
module modbus_data_model_register_map #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_BURST   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[3:0], address[19:4], table_select[21:20], entry_index[26:22],
  // data_value[42:27], write_count[47:43].
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], read_value[17:2], zero padding above.
  output logic [23:0] m_axis_tdata
);
  import mdmrm_pkg::*;

  logic [15:0] sw_addr_q;
  logic [4:0]  sw_idx_q;
  logic [5:0]  coil_use_q, disc_use_q, hold_use_q, inreg_use_q;
  st_e         state_q, state_d;
  logic [3:0]  cmd_q;
  logic [15:0] addr_q, data_q;
  logic [1:0]  tsel_q;
  logic [4:0]  ent_q, cnt_q;
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [15:0] rv_q, rv_d;

  logic [TABLE_DEPTH-1:0] hits, first_oh, coil_v, disc_v;
  logic [15:0]            hold_v [TABLE_DEPTH];
  logic [15:0]            inreg_v [TABLE_DEPTH];
  logic [IDXW-1:0]        first_idx;
  logic                   found, sw_on, wr_ok, accept, exec, trunc;
  logic                   rd_coil, rd_disc;
  logic [15:0]            rd_hold, rd_inreg;
  logic [CNTW-1:0]        cnt_c;
  logic [5:0]             coil_lim;
  logic [3:0]             in_cmd;
  tbl_e                   in_tbl;
  cell_ctrl_t             ctrl;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_cmd = s_axis_tdata[3:0];

  always_comb begin
    case (in_cmd)
      CMD_RD_DISC:                in_tbl = TBL_DISC;
      CMD_RD_HOLD, CMD_WR_HOLD:   in_tbl = TBL_HOLD;
      CMD_RD_INREG:               in_tbl = TBL_INREG;
      default:                    in_tbl = TBL_COIL;
    endcase
  end

  always_comb begin
    first_oh  = hits & (~hits + TABLE_DEPTH'(1));
    found     = |hits;
    first_idx = '0;
    rd_coil   = 1'b0;
    rd_disc   = 1'b0;
    rd_hold   = '0;
    rd_inreg  = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (first_oh[k]) first_idx = first_idx | IDXW'(k);
      rd_coil  = rd_coil | (first_oh[k] & coil_v[k]);
      rd_disc  = rd_disc | (first_oh[k] & disc_v[k]);
      rd_hold  = rd_hold | ({16{first_oh[k]}} & hold_v[k]);
      rd_inreg = rd_inreg | ({16{first_oh[k]}} & inreg_v[k]);
    end
    sw_on = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (int'(sw_idx_q) == k) sw_on = coil_v[k];
    end
    case (cmd_q)
      CMD_WR_COIL:               wr_ok = (addr_q == sw_addr_q) || sw_on;
      CMD_WR_COILS, CMD_WR_HOLD: wr_ok = sw_on;
      default:                   wr_ok = 1'b1;
    endcase
    cnt_c    = (int'(cnt_q) > MAX_BURST) ? CNTW'(MAX_BURST) : CNTW'(cnt_q);
    coil_lim = (int'(coil_use_q) > TABLE_DEPTH) ? 6'(TABLE_DEPTH) : coil_use_q;
    trunc    = (int'(first_idx) + int'(cnt_c)) > int'(coil_lim);
  end

  always_comb begin
    status_d = STATUS_OK;
    rv_d     = '0;
    case (cmd_q)
      CMD_RD_COIL:  if (found) rv_d = 16'(rd_coil);  else status_d = STATUS_MISS;
      CMD_RD_DISC:  if (found) rv_d = 16'(rd_disc);  else status_d = STATUS_MISS;
      CMD_RD_HOLD:  if (found) rv_d = rd_hold;       else status_d = STATUS_MISS;
      CMD_RD_INREG: if (found) rv_d = rd_inreg;      else status_d = STATUS_MISS;
      CMD_WR_COIL, CMD_WR_HOLD: begin
        if (wr_ok && !found) status_d = STATUS_MISS;
      end
      CMD_WR_COILS: begin
        if (wr_ok) begin
          if (!found) status_d = STATUS_MISS;
          else if (trunc) status_d = STATUS_TRUNC;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    exec    = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (exec) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.look_en   = accept;
    ctrl.look_tbl  = in_tbl;
    ctrl.look_addr = s_axis_tdata[19:4];
    case (in_tbl)
      TBL_COIL: ctrl.look_use = coil_use_q;
      TBL_DISC: ctrl.look_use = disc_use_q;
      TBL_HOLD: ctrl.look_use = hold_use_q;
      default:  ctrl.look_use = inreg_use_q;
    endcase
    ctrl.exec_en   = exec;
    ctrl.cmd       = cmd_q;
    ctrl.wr_ok     = wr_ok && found;
    ctrl.tsel      = tbl_e'(tsel_q);
    ctrl.ent       = ent_q;
    ctrl.data      = data_q;
    ctrl.tag       = addr_q;
    ctrl.first_idx = first_idx;
    ctrl.cnt       = cnt_c;
    ctrl.coil_use  = coil_use_q;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    mdmrm_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .first_i (first_oh[g]),
      .hit_o   (hits[g]),
      .coil_o  (coil_v[g]),
      .disc_o  (disc_v[g]),
      .hold_o  (hold_v[g]),
      .inreg_o (inreg_v[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tdata[3:0];
      addr_q <= s_axis_tdata[19:4];
      tsel_q <= s_axis_tdata[21:20];
      ent_q  <= s_axis_tdata[26:22];
      data_q <= s_axis_tdata[42:27];
      cnt_q  <= s_axis_tdata[47:43];
    end
    if (exec) begin
      status_q <= status_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sw_addr_q   <= SWITCH_ADDR_RESET;
      sw_idx_q    <= '0;
      coil_use_q  <= '0;
      disc_use_q  <= '0;
      hold_use_q  <= '0;
      inreg_use_q <= '0;
    end else begin
      state_q <= state_d;
      if (exec) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SWITCH_ADDR: sw_addr_q   <= cfg_wdata_i;
          REG_SWITCH_IDX:  sw_idx_q    <= cfg_wdata_i[4:0];
          REG_COIL_USE:    coil_use_q  <= cfg_wdata_i[5:0];
          REG_DISC_USE:    disc_use_q  <= cfg_wdata_i[5:0];
          REG_HOLD_USE:    hold_use_q  <= cfg_wdata_i[5:0];
          REG_INREG_USE:   inreg_use_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, rv_q, status_q};

endmodule

/* rtl/mdmrm_checker.sv */
// ----------------------------------------------------------------------------
// Modbus register map checker
// Port-level assertions on the register map, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_data_model_register_map_macros.svh"

module mdmrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `MDMRM_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while one is in progress")
  `MDMRM_ASSERT(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status code")
  `MDMRM_ASSERT(a_fail_zero, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[17:2] == 16'd0, "read value set on failed item")
  `MDMRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind modbus_data_model_register_map mdmrm_checker u_mdmrm_checker (.*);

/* tb/mdmrm_response_checker.sv */
// ----------------------------------------------------------------------------
// Modbus register map response checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the four tables, predicts status and read value for every accepted
// command and compares them in order with the results the block returns.
// ----------------------------------------------------------------------------
module mdmrm_response_checker
  import mdmrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          pending_o,
  output int          fail_count_o,
  output int          items_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] tag_mem [4][32];
  logic [15:0] val_mem [4][32];
  logic [5:0]  use_cnt [4];
  logic [15:0] switch_addr;
  logic [4:0]  switch_idx;
  logic [1:0]  exp_status_q[$];
  logic [15:0] exp_read_q[$];

  assign pending_o = exp_status_q.size();

  function automatic int find_entry(int tbl, logic [15:0] addr);
    int n;
    n = (use_cnt[tbl] > 32) ? 32 : int'(use_cnt[tbl]);
    for (int k = 0; k < n; k++) begin
      if (tag_mem[tbl][k] == addr) return k;
    end
    return 32;
  endfunction

  task automatic apply_command(input logic [47:0] d, output logic [1:0] st,
                               output logic [15:0] rv);
    logic [3:0]  cmd;
    logic [15:0] addr;
    logic [1:0]  tsel;
    logic [4:0]  ent;
    logic [15:0] data;
    int          cnt;
    int          i;
    int          lim;
    logic        gate;
    cmd  = d[3:0];
    addr = d[19:4];
    tsel = d[21:20];
    ent  = d[26:22];
    data = d[42:27];
    cnt  = int'(d[47:43]);
    st   = STATUS_OK;
    rv   = '0;
    gate = val_mem[TBL_COIL][switch_idx] != 0;
    case (cmd)
      CMD_RD_COIL, CMD_RD_DISC, CMD_RD_HOLD, CMD_RD_INREG: begin
        int tbl;
        tbl = (cmd == CMD_RD_COIL) ? TBL_COIL : (cmd == CMD_RD_DISC) ? TBL_DISC :
              (cmd == CMD_RD_HOLD) ? TBL_HOLD : TBL_INREG;
        i = find_entry(tbl, addr);
        if (i < 32) rv = val_mem[tbl][i];
        else st = STATUS_MISS;
      end
      CMD_WR_COIL: begin
        if (addr == switch_addr || gate) begin
          i = find_entry(TBL_COIL, addr);
          if (i < 32) val_mem[TBL_COIL][i] = 16'(data != 0);
          else st = STATUS_MISS;
        end
      end
      CMD_WR_COILS: begin
        if (gate) begin
          i = find_entry(TBL_COIL, addr);
          if (i >= 32) begin
            st = STATUS_MISS;
          end else begin
            if (cnt > 16) cnt = 16;
            lim = (use_cnt[TBL_COIL] > 32) ? 32 : int'(use_cnt[TBL_COIL]);
            for (int j = 0; j < cnt; j++) begin
              if (i + j >= lim) begin
                st = STATUS_TRUNC;
                break;
              end
              val_mem[TBL_COIL][i+j] = 16'(data[j]);
            end
          end
        end
      end
      CMD_WR_HOLD: begin
        if (gate) begin
          i = find_entry(TBL_HOLD, addr);
          if (i < 32) val_mem[TBL_HOLD][i] = data;
          else st = STATUS_MISS;
        end
      end
      CMD_SET_TAG: tag_mem[tsel][ent] = addr;
      CMD_SET_VALUE: begin
        if (tsel == TBL_COIL || tsel == TBL_DISC) val_mem[tsel][ent] = 16'(data != 0);
        else val_mem[tsel][ent] = data;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [1:0]  st;
    logic [15:0] rv;
    if (!rst_ni) begin
      for (int t = 0; t < 4; t++) begin
        use_cnt[t] = '0;
        for (int k = 0; k < 32; k++) begin
          tag_mem[t][k] = '0;
          val_mem[t][k] = '0;
        end
      end
      switch_addr = SWITCH_ADDR_RESET;
      switch_idx = '0;
      exp_status_q.delete();
      exp_read_q.delete();
      fail_count_o = 0;
      items_o = 0;
      results_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (exp_status_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("Unexpected result: status %0d read 0x%04h", m_axis_tdata[1:0],
                     m_axis_tdata[17:2]);
        end else begin
          st = exp_status_q.pop_front();
          rv = exp_read_q.pop_front();
          if (st !== m_axis_tdata[1:0] || rv !== m_axis_tdata[17:2]) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch on result %0d: expected status %0d read 0x%04h, got %0d 0x%04h",
                       results_o, st, rv, m_axis_tdata[1:0], m_axis_tdata[17:2]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_o++;
        apply_command(s_axis_tdata, st, rv);
        exp_status_q.push_back(st);
        exp_read_q.push_back(rv);
      end
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_SWITCH_ADDR: switch_addr = cfg_wdata_i;
          REG_SWITCH_IDX:  switch_idx = cfg_wdata_i[4:0];
          REG_COIL_USE:    use_cnt[TBL_COIL] = cfg_wdata_i[5:0];
          REG_DISC_USE:    use_cnt[TBL_DISC] = cfg_wdata_i[5:0];
          REG_HOLD_USE:    use_cnt[TBL_HOLD] = cfg_wdata_i[5:0];
          REG_INREG_USE:   use_cnt[TBL_INREG] = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Modbus register map testbench
// Loads every tag, runs directed commands over the corner cases and then
// random command streams under several table settings, with random idling
// on both channels in all but the last setting; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mdmrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  int          pending;
  int          fail_count;
  int          items;
  int          results;
  bit          quiet = 1'b0;
  logic [15:0] addr_pool [16];
  logic [15:0] tb_tag [4][32];
  logic [4:0]  sw_idx = '0;

  modbus_data_model_register_map u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  mdmrm_response_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .fail_count_o(fail_count), .items_o(items), .results_o(results)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    int hold;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      if (hold == 0) m_axis_tready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(1, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    int idle;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(logic [3:0] cmd, logic [15:0] addr, logic [1:0] tsel,
                      logic [4:0] ent, logic [15:0] data, logic [4:0] cnt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata <= {cnt, data, ent, tsel, addr, cmd};
    s_axis_tvalid <= 1'b1;
    if (cmd == CMD_SET_TAG) tb_tag[tsel][ent] = addr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_SWITCH_IDX) sw_idx = val[4:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_addr(int tbl);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return addr_pool[$urandom_range(0, 15)];
      default: return tb_tag[tbl][$urandom_range(0, 31)];
    endcase
  endfunction

  task automatic random_item();
    logic [3:0]  cmd;
    logic [4:0]  cnt;
    int          r;
    r = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
    if (r < 12) cmd = CMD_RD_COIL;
    else if (r < 20) cmd = CMD_RD_DISC;
    else if (r < 34) cmd = CMD_WR_COIL;
    else if (r < 50) cmd = CMD_WR_COILS;
    else if (r < 60) cmd = CMD_RD_HOLD;
    else if (r < 68) cmd = CMD_RD_INREG;
    else if (r < 80) cmd = CMD_WR_HOLD;
    else if (r < 86) cmd = CMD_SET_TAG;
    else if (r < 96) cmd = CMD_SET_VALUE;
    else cmd = 4'($urandom_range(9, 15));
    case (cmd)
      CMD_RD_DISC: send(cmd, pick_addr(TBL_DISC), 2'($urandom), 5'($urandom), 16'($urandom),
                        cnt);
      CMD_RD_HOLD, CMD_WR_HOLD:
        send(cmd, pick_addr(TBL_HOLD), 2'($urandom), 5'($urandom), 16'($urandom), cnt);
      CMD_RD_INREG: send(cmd, pick_addr(TBL_INREG), 2'($urandom), 5'($urandom),
                         16'($urandom), cnt);
      CMD_SET_TAG, CMD_SET_VALUE:
        send(cmd, addr_pool[$urandom_range(0, 15)], 2'($urandom), 5'($urandom),
             ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom), cnt);
      default: send(cmd, pick_addr(TBL_COIL), 2'($urandom), 5'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom), cnt);
    endcase
  endtask

  initial begin
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    addr_pool[2] = SWITCH_ADDR_RESET;
    addr_pool[3] = 16'hAAAA;
    addr_pool[4] = 16'h5555;
    for (int k = 5; k < 16; k++) addr_pool[k] = 16'($urandom_range(0, 65535));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int t = 0; t < 4; t++)
      for (int k = 0; k < 32; k++)
        send(CMD_SET_TAG, addr_pool[$urandom_range(0, 15)], 2'(t), 5'(k), '0, '0);
    send(CMD_SET_TAG, SWITCH_ADDR_RESET, TBL_COIL, 5'd0, '0, '0);
    send(CMD_SET_TAG, 16'h1234, TBL_COIL, 5'd28, '0, '0);
    write_reg(REG_COIL_USE, 16'd30);
    write_reg(REG_DISC_USE, 16'd32);
    write_reg(REG_HOLD_USE, 16'd32);
    write_reg(REG_INREG_USE, 16'd63);

    // Gate closed: writes are dropped, then the switch address opens it.
    send(CMD_WR_HOLD, tb_tag[TBL_HOLD][3], '0, '0, 16'hBEEF, '0);
    send(CMD_WR_COILS, tb_tag[TBL_COIL][5], '0, '0, 16'hFFFF, 5'd16);
    send(CMD_WR_COIL, tb_tag[TBL_COIL][7], '0, '0, 16'h0001, '0);
    send(CMD_WR_COIL, SWITCH_ADDR_RESET, '0, '0, 16'h8000, '0);
    send(CMD_WR_HOLD, tb_tag[TBL_HOLD][3], '0, '0, 16'hFFFF, '0);
    send(CMD_RD_HOLD, tb_tag[TBL_HOLD][3], '0, '0, '0, '0);
    send(CMD_WR_COILS, 16'h1234, '0, '0, 16'h0005, 5'd31);
    send(CMD_WR_COILS, 16'h1234, '0, '0, 16'h0003, 5'd0);
    send(CMD_RD_COIL, 16'h1234, '0, '0, '0, '0);
    send(CMD_SET_VALUE, '0, TBL_COIL, 5'd1, 16'hFFFF, '0);
    send(CMD_SET_VALUE, '0, TBL_DISC, 5'd31, 16'h0100, '0);
    send(CMD_SET_VALUE, '0, TBL_HOLD, 5'd0, 16'hFFFF, '0);
    send(CMD_SET_VALUE, '0, TBL_INREG, 5'd31, 16'h8001, '0);
    send(CMD_RD_DISC, tb_tag[TBL_DISC][31], '0, '0, '0, '0);
    send(CMD_RD_INREG, tb_tag[TBL_INREG][31], '0, '0, '0, '0);
    send(CMD_RD_COIL, 16'h1234, '0, '0, '0, '0);
    send(4'd15, 16'hFFFF, 2'd3, 5'd31, 16'hFFFF, 5'd31);
    send(4'd9, '0, '0, '0, '0, '0);
    write_reg(REG_SWITCH_ADDR, 16'hFFFF);
    write_reg(REG_SWITCH_IDX, 16'd31);
    write_reg(REG_COIL_USE, 16'd0);
    send(CMD_RD_COIL, tb_tag[TBL_COIL][0], '0, '0, '0, '0);
    send(CMD_WR_HOLD, tb_tag[TBL_HOLD][0], '0, '0, 16'h1111, '0);

    for (int phase = 0; phase < 8; phase++) begin
      quiet = (phase == 7);
      write_reg(REG_SWITCH_ADDR, (phase == 0) ? 16'h0000 : (phase == 1) ? 16'hFFFF :
                tb_tag[TBL_COIL][$urandom_range(0, 31)]);
      write_reg(REG_SWITCH_IDX, (phase == 2) ? 16'd0 : (phase == 3) ? 16'd31 :
                16'($urandom_range(0, 31)));
      write_reg(REG_COIL_USE, (phase == 0) ? 16'd32 : (phase == 4) ? 16'd1 :
                16'($urandom_range(0, 63)));
      write_reg(REG_DISC_USE, (phase == 5) ? 16'd0 : 16'($urandom_range(0, 63)));
      write_reg(REG_HOLD_USE, (phase == 6) ? 16'd63 : 16'($urandom_range(0, 32)));
      write_reg(REG_INREG_USE, 16'($urandom_range(0, 63)));
      for (int n = 0; n < 215; n++) begin
        if (phase != 5 && n % 40 == 0)
          send(CMD_SET_VALUE, '0, TBL_COIL, sw_idx, 16'h0001, '0);
        random_item();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d commands over all nine operations and eight table settings;", items);
    $display("%0d results compared, %0d mismatches.", results, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
